FILE: hdl/dchwg_pkg.sv
package dchwg_pkg;

  // Event kinds carried on the input tuser
  localparam logic [2:0] KIND_START    = 3'd0;
  localparam logic [2:0] KIND_STOP     = 3'd1;
  localparam logic [2:0] KIND_MARK0    = 3'd2;
  localparam logic [2:0] KIND_MARK1    = 3'd3;
  localparam logic [2:0] KIND_SNAPSHOT = 3'd4;

  // Latched stale peer
  localparam logic [1:0] STALE_NONE  = 2'd0;
  localparam logic [1:0] STALE_CORE0 = 2'd1;
  localparam logic [1:0] STALE_CORE1 = 2'd2;

  // Reported events
  localparam logic [1:0] EV_NONE        = 2'd0;
  localparam logic [1:0] EV_RECOVERED   = 2'd1;
  localparam logic [1:0] EV_CORE0_STALE = 2'd2;
  localparam logic [1:0] EV_CORE1_STALE = 2'd3;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_GRACE      = 2'd0;
  localparam logic [1:0] REG_C0_START   = 2'd1;
  localparam logic [1:0] REG_C1_START   = 2'd2;

  localparam int unsigned PADDR_W    = 4;
  localparam logic [30:0] GRACE_RESET = 31'd750000;

  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned OUT_TDATA_W = 168;

  typedef struct packed {
    logic [30:0] grace_window_us;
    logic [31:0] core0_start_marker;
    logic [31:0] core1_start_marker;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] now_time_us;
    logic [31:0] new_session_id;
    logic [31:0] progress_marker;
  } item_t;

  typedef struct packed {
    logic        feed;
    logic        arm;
    logic        disarm;
    logic [1:0]  stale_code;
    logic [1:0]  event_code;
    logic        is_active;
    logic [31:0] current_session;
    logic [31:0] core0_marker_out;
    logic [31:0] core1_marker_out;
    logic [30:0] core0_age_us;
    logic [30:0] core1_age_us;
  } res_t;

  // Wrap-safe age: signed difference, zero when not positive
  function automatic logic [30:0] age_of(logic [31:0] now, logic [31:0] then);
    logic [31:0] diff;
    diff = now - then;
    return diff[31] ? 31'd0 : diff[30:0];
  endfunction

endpackage

FILE: hdl/dual_core_heartbeat_watchdog_gate.sv
// Dual-core heartbeat watchdog gate. Each input transaction is one event
// (session start, stop, a progress mark from core 0 or core 1, or a
// snapshot) and yields exactly one output transaction with the feed/arm/
// disarm flags, the stale-peer latch, any stale/recovery event, and the
// session id, markers and ages after the event. Events pass through an
// input register, compare/subtract logic against the session state, and
// an output register; one event per cycle is sustained as long as the
// output side keeps tready high. The output register stalls the input only
// when it is full and not taken. Registers (APB, byte address 4*i): 0x0
// grace window in us (31 bits, reset 750000), 0x4 core 0 start marker,
// 0x8 core 1 start marker.
// Write registers only while no event is in flight.
module dual_core_heartbeat_watchdog_gate (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // APB configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dchwg_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // Event input
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // now_time_us[31:0], new_session_id[63:32], progress_marker[95:64]
  input  logic [dchwg_pkg::IN_TDATA_W-1:0]  s_tdata,
  // kind[2:0]
  input  logic [2:0]                        s_tuser,
  // Result output
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // feed[0], arm[1], disarm[2], stale_code[4:3], event_code[6:5],
  // is_active[7], current_session[39:8], core0_marker_out[71:40],
  // core1_marker_out[103:72], core0_age_us[134:104],
  // core1_age_us[165:135], zero[167:166]
  output logic [dchwg_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import dchwg_pkg::*;

  cfg_t  cfg;
  item_t in_item_q;
  logic  in_valid_q;
  res_t  res;
  res_t  out_res_q;
  logic  out_valid_q;
  logic  advance;

  dchwg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Move the input register into the result register
  assign advance  = in_valid_q & (~out_valid_q | m_tready);
  assign s_tready = ~in_valid_q | advance;

  dchwg_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (in_item_q),
    .step_i (advance),
    .res_o  (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready) begin
      in_valid_q <= s_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready && s_tvalid) begin
      in_item_q.kind            <= s_tuser;
      in_item_q.now_time_us     <= s_tdata[31:0];
      in_item_q.new_session_id  <= s_tdata[63:32];
      in_item_q.progress_marker <= s_tdata[95:64];
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {2'b00,
                     out_res_q.core1_age_us,
                     out_res_q.core0_age_us,
                     out_res_q.core1_marker_out,
                     out_res_q.core0_marker_out,
                     out_res_q.current_session,
                     out_res_q.is_active,
                     out_res_q.event_code,
                     out_res_q.stale_code,
                     out_res_q.disarm,
                     out_res_q.arm,
                     out_res_q.feed};

  // A session start always feeds, activates and clears the stale latch
  a_arm_feeds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && out_res_q.arm |->
      out_res_q.feed && out_res_q.is_active && out_res_q.stale_code == STALE_NONE)
    else $error("arm without feed/active/clear latch");

  // Reported event agrees with the latch after the event
  a_event_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && out_res_q.event_code != EV_NONE |->
      (out_res_q.event_code == EV_RECOVERED && out_res_q.feed &&
       out_res_q.stale_code == STALE_NONE) ||
      (out_res_q.event_code == EV_CORE0_STALE && !out_res_q.feed &&
       out_res_q.stale_code == STALE_CORE0) ||
      (out_res_q.event_code == EV_CORE1_STALE && !out_res_q.feed &&
       out_res_q.stale_code == STALE_CORE1))
    else $error("event code does not match stale latch");

  // Disarm leaves the session inactive
  a_disarm_inactive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && out_res_q.disarm |-> !out_res_q.is_active && !out_res_q.feed)
    else $error("disarm with active session");

  // Input stalls only behind a full, untaken result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready |-> m_tvalid && !m_tready && in_valid_q)
    else $error("input stalled without output back-pressure");

endmodule

FILE: hdl/dchwg_cfg.sv
module dchwg_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dchwg_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output dchwg_pkg::cfg_t               cfg_o
);
  import dchwg_pkg::*;

  cfg_t        cfg_q, cfg_d;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_GRACE:    cfg_d.grace_window_us    = pwdata[30:0];
        REG_C0_START: cfg_d.core0_start_marker = pwdata;
        REG_C1_START: cfg_d.core1_start_marker = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grace_window_us    <= GRACE_RESET;
      cfg_q.core0_start_marker <= '0;
      cfg_q.core1_start_marker <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_GRACE:    prdata = {1'b0, cfg_q.grace_window_us};
      REG_C0_START: prdata = cfg_q.core0_start_marker;
      REG_C1_START: prdata = cfg_q.core1_start_marker;
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/dchwg_core.sv
module dchwg_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dchwg_pkg::cfg_t  cfg_i,
  input  dchwg_pkg::item_t item_i,
  input  logic             step_i,
  output dchwg_pkg::res_t  res_o
);
  import dchwg_pkg::*;

  logic        active_q, active_d;
  logic [31:0] session_q, session_d;
  logic [31:0] c0_time_q, c0_time_d;
  logic [31:0] c1_time_q, c1_time_d;
  logic [31:0] c0_mark_q, c0_mark_d;
  logic [31:0] c1_mark_q, c1_mark_d;
  logic [1:0]  stale_q, stale_d;
  logic        feed, arm, disarm;
  logic [1:0]  ev;
  logic [30:0] peer_age0, peer_age1;

  assign peer_age0 = age_of(item_i.now_time_us, c0_time_q);
  assign peer_age1 = age_of(item_i.now_time_us, c1_time_q);

  // Event decode and state update
  always_comb begin
    active_d  = active_q;
    session_d = session_q;
    c0_time_d = c0_time_q;
    c1_time_d = c1_time_q;
    c0_mark_d = c0_mark_q;
    c1_mark_d = c1_mark_q;
    stale_d   = stale_q;
    feed      = 1'b0;
    arm       = 1'b0;
    disarm    = 1'b0;
    ev        = EV_NONE;
    unique case (item_i.kind)
      KIND_START: begin
        active_d  = 1'b1;
        session_d = item_i.new_session_id;
        c0_time_d = item_i.now_time_us;
        c1_time_d = item_i.now_time_us;
        c0_mark_d = cfg_i.core0_start_marker;
        c1_mark_d = cfg_i.core1_start_marker;
        stale_d   = STALE_NONE;
        arm       = 1'b1;
        feed      = 1'b1;
      end
      KIND_STOP: begin
        if (active_q) begin
          active_d = 1'b0;
          disarm   = 1'b1;
        end
      end
      KIND_MARK0: begin
        if (active_q) begin
          c0_time_d = item_i.now_time_us;
          c0_mark_d = item_i.progress_marker;
          if (peer_age1 <= cfg_i.grace_window_us) begin
            feed = 1'b1;
            if (stale_q != STALE_NONE) begin
              stale_d = STALE_NONE;
              ev      = EV_RECOVERED;
            end
          end else if (stale_q != STALE_CORE1) begin
            stale_d = STALE_CORE1;
            ev      = EV_CORE1_STALE;
          end
        end
      end
      KIND_MARK1: begin
        if (active_q) begin
          c1_time_d = item_i.now_time_us;
          c1_mark_d = item_i.progress_marker;
          if (peer_age0 <= cfg_i.grace_window_us) begin
            feed = 1'b1;
            if (stale_q != STALE_NONE) begin
              stale_d = STALE_NONE;
              ev      = EV_RECOVERED;
            end
          end else if (stale_q != STALE_CORE0) begin
            stale_d = STALE_CORE0;
            ev      = EV_CORE0_STALE;
          end
        end
      end
      default: ; // snapshot and unused codes change nothing
    endcase
  end

  // Result reports the state after the event
  always_comb begin
    res_o.feed             = feed;
    res_o.arm              = arm;
    res_o.disarm           = disarm;
    res_o.stale_code       = stale_d;
    res_o.event_code       = ev;
    res_o.is_active        = active_d;
    res_o.current_session  = session_d;
    res_o.core0_marker_out = c0_mark_d;
    res_o.core1_marker_out = c1_mark_d;
    res_o.core0_age_us     = age_of(item_i.now_time_us, c0_time_d);
    res_o.core1_age_us     = age_of(item_i.now_time_us, c1_time_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      session_q <= '0;
      c0_time_q <= '0;
      c1_time_q <= '0;
      c0_mark_q <= '0;
      c1_mark_q <= '0;
      stale_q   <= STALE_NONE;
    end else if (step_i) begin
      active_q  <= active_d;
      session_q <= session_d;
      c0_time_q <= c0_time_d;
      c1_time_q <= c1_time_d;
      c0_mark_q <= c0_mark_d;
      c1_mark_q <= c1_mark_d;
      stale_q   <= stale_d;
    end
  end

endmodule

FILE: tb/sv/dual_core_heartbeat_watchdog_gate_tb.sv
module dual_core_heartbeat_watchdog_gate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dchwg_pkg::*;

  // Kind codes 5..7 carry no name in the package and act as snapshots
  localparam logic [2:0] KIND_LAST = 3'd7;

  // Clock and reset
  logic clk_i = 1'b0;
  logic rst_ni;
  always #5 clk_i = ~clk_i;

  // Block ports
  logic                   psel, penable, pwrite;
  logic [PADDR_W-1:0]     paddr;
  logic [31:0]            pwdata, prdata;
  logic                   pready;
  logic                   s_tvalid, s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [2:0]             s_tuser;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  dual_core_heartbeat_watchdog_gate dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Shadow of the gate: configuration and session state
  logic [30:0] grace_us     = GRACE_RESET;
  logic [31:0] c0_start_mk  = '0;
  logic [31:0] c1_start_mk  = '0;
  logic        sess_active  = 1'b0;
  logic [31:0] sess_id      = '0;
  logic [31:0] c0_time      = '0;
  logic [31:0] c1_time      = '0;
  logic [31:0] c0_mark      = '0;
  logic [31:0] c1_mark      = '0;
  logic [1:0]  latched_peer = STALE_NONE;

  res_t        expected_results[$];
  int          fail_cnt     = 0;
  int          n_events     = 0;
  int          n_feeds      = 0;
  int          n_stale_ev   = 0;
  int          n_recover    = 0;
  int          n_configs    = 0;

  // Stimulus knobs
  logic        src_idle_en  = 1'b1;
  logic        sink_idle_en = 1'b1;
  logic [31:0] tb_now       = '0;
  int          hold_len     = 0;
  logic        hold_tgl     = 1'b0;

  // Age of a timestamp: wrap-safe difference, zero unless positive
  function automatic logic [30:0] elapsed_us(logic [31:0] now_us, logic [31:0] then_us);
    logic [31:0] d;
    d = now_us - then_us;
    if (d[31]) return '0;
    return d[30:0];
  endfunction

  // Apply one event to the shadow state and build the result it must produce
  function automatic res_t predict_gate_result(item_t it);
    res_t        r;
    logic [31:0] peer_time;
    logic [1:0]  stale_code, stale_event;
    r = '0;
    case (it.kind) inside
      KIND_START: begin
        sess_active  = 1'b1;
        sess_id      = it.new_session_id;
        c0_time      = it.now_time_us;
        c1_time      = it.now_time_us;
        c0_mark      = c0_start_mk;
        c1_mark      = c1_start_mk;
        latched_peer = STALE_NONE;
        r.arm        = 1'b1;
        r.feed       = 1'b1;
      end
      KIND_STOP: begin
        if (sess_active) begin
          sess_active = 1'b0;
          r.disarm    = 1'b1;
        end
      end
      KIND_MARK0, KIND_MARK1: begin
        if (sess_active) begin
          if (it.kind == KIND_MARK0) begin
            c0_time     = it.now_time_us;
            c0_mark     = it.progress_marker;
            peer_time   = c1_time;
            stale_code  = STALE_CORE1;
            stale_event = EV_CORE1_STALE;
          end else begin
            c1_time     = it.now_time_us;
            c1_mark     = it.progress_marker;
            peer_time   = c0_time;
            stale_code  = STALE_CORE0;
            stale_event = EV_CORE0_STALE;
          end
          // feed only while the peer is inside the grace window
          if (elapsed_us(it.now_time_us, peer_time) <= grace_us) begin
            if (latched_peer != STALE_NONE) begin
              latched_peer = STALE_NONE;
              r.event_code = EV_RECOVERED;
            end
            r.feed = 1'b1;
          end else if (latched_peer != stale_code) begin
            latched_peer = stale_code;
            r.event_code = stale_event;
          end
        end
      end
      default: ;
    endcase
    r.stale_code       = latched_peer;
    r.is_active        = sess_active;
    r.current_session  = sess_id;
    r.core0_marker_out = c0_mark;
    r.core1_marker_out = c1_mark;
    r.core0_age_us     = elapsed_us(it.now_time_us, c0_time);
    r.core1_age_us     = elapsed_us(it.now_time_us, c1_time);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endtask

  // Send one event transaction; expectation is recorded at acceptance
  task automatic send_event(input logic [2:0] kind, input logic [31:0] now_us,
                            input logic [31:0] sid, input logic [31:0] marker);
    item_t it;
    res_t  r;
    it.kind            = kind;
    it.now_time_us     = now_us;
    it.new_session_id  = sid;
    it.progress_marker = marker;
    while (src_idle_en && $urandom_range(99) < 19) begin
      @(negedge clk_i);
      s_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {marker, sid, now_us};
    do @(posedge clk_i); while (!s_tready);
    r = predict_gate_result(it);
    expected_results.push_back(r);
    n_events++;
    n_feeds    += r.feed;
    n_stale_ev += (r.event_code == EV_CORE0_STALE || r.event_code == EV_CORE1_STALE);
    n_recover  += (r.event_code == EV_RECOVERED);
  endtask

  // Drop valid and wait for every outstanding result, then let the pipe settle
  task automatic drain_results();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [1:0] idx, input logic [31:0] want);
    logic [31:0] rd;
    apb_access(1'b0, idx, '0, rd);
    check_field("prdata", want, rd);
  endtask

  // Reprogram all registers while idle and read them back
  task automatic set_config(input logic [30:0] grace, input logic [31:0] mk0,
                            input logic [31:0] mk1);
    logic [31:0] rd;
    drain_results();
    apb_access(1'b1, REG_GRACE, {1'b0, grace}, rd);
    apb_access(1'b1, REG_C0_START, mk0, rd);
    apb_access(1'b1, REG_C1_START, mk1, rd);
    grace_us    = grace;
    c0_start_mk = mk0;
    c1_start_mk = mk1;
    n_configs++;
    apb_read_check(REG_GRACE, {1'b0, grace_us});
    apb_read_check(REG_C0_START, c0_start_mk);
    apb_read_check(REG_C1_START, c1_start_mk);
  endtask

  // Receiver: random stalls plus long hold-offs requested by a test
  always @(negedge clk_i) begin : result_sink
    int   stall_left;
    logic hold_seen;
    if (hold_tgl !== hold_seen) begin
      hold_seen  = hold_tgl;
      stall_left = hold_len;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(99) < 19) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    result_sink.stall_left = 0;
    result_sink.hold_seen  = 1'b0;
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no event outstanding: 0x%0h", m_tdata);
        fail_cnt++;
      end else begin
        want = expected_results.pop_front();
        check_field("feed",             32'(want.feed),        32'(m_tdata[0]));
        check_field("arm",              32'(want.arm),         32'(m_tdata[1]));
        check_field("disarm",           32'(want.disarm),      32'(m_tdata[2]));
        check_field("stale_code",       32'(want.stale_code),  32'(m_tdata[4:3]));
        check_field("event_code",       32'(want.event_code),  32'(m_tdata[6:5]));
        check_field("is_active",        32'(want.is_active),   32'(m_tdata[7]));
        check_field("current_session",  want.current_session,  m_tdata[39:8]);
        check_field("core0_marker_out", want.core0_marker_out, m_tdata[71:40]);
        check_field("core1_marker_out", want.core1_marker_out, m_tdata[103:72]);
        check_field("core0_age_us",     32'(want.core0_age_us), 32'(m_tdata[134:104]));
        check_field("core1_age_us",     32'(want.core1_age_us), 32'(m_tdata[165:135]));
      end
    end
  end

  // Reset values read back before any write
  task automatic test_register_reset();
    apb_read_check(REG_GRACE, {1'b0, GRACE_RESET});
    apb_read_check(REG_C0_START, '0);
    apb_read_check(REG_C1_START, '0);
  endtask

  // Hand-picked events: boundaries, wrap, latch transitions, ignored kinds
  task automatic test_directed_events();
    set_config(31'd100, 32'hFFFF_FFFF, 32'h0000_0000);
    send_event(KIND_MARK0,    32'd10, 32'd0, 32'hFFFF_FFFF);   // mark while inactive
    send_event(KIND_STOP,     32'd20, 32'hFFFF_FFFF, 32'd0);   // stop while inactive
    send_event(KIND_SNAPSHOT, 32'd0, 32'd0, 32'd0);
    send_event(KIND_START,    32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'd0);
    send_event(KIND_MARK0,    32'h0000_0050, 32'd0, 32'h1234_5678); // time wrapped
    send_event(KIND_MARK1,    32'h0000_00B4, 32'd0, 32'hFFFF_FFFF); // age == grace
    send_event(KIND_MARK0,    32'h0000_0119, 32'd0, 32'd0);     // age grace+1: core1 stale
    send_event(KIND_MARK0,    32'h0000_0200, 32'd0, 32'd1);     // still stale, no event
    send_event(KIND_MARK1,    32'h0000_0201, 32'd0, 32'd2);     // recovery
    send_event(KIND_MARK1,    32'h0000_0300, 32'd0, 32'd3);     // core0 stale
    send_event(KIND_MARK0,    32'h0000_02FF, 32'd0, 32'd4);     // time ran backward
    send_event(KIND_MARK0,    32'h8000_0300, 32'd0, 32'd5);     // half-range jump clamps
    send_event(KIND_SNAPSHOT, 32'h8000_0301, 32'hDEAD_BEEF, 32'hFFFF_FFFF);
    send_event(KIND_START,    32'd0, 32'd0, 32'hFFFF_FFFF);     // restart while active
    send_event(KIND_STOP,     32'd5, 32'd0, 32'd0);
    send_event(KIND_STOP,     32'd6, 32'd0, 32'd0);
    send_event(KIND_MARK1,    32'd7, 32'd0, 32'd55);
    for (int k = KIND_SNAPSHOT + 1; k <= KIND_LAST; k++)
      send_event(3'(k), $urandom(), $urandom(), $urandom());
    send_event(KIND_START,    32'h0000_1000, 32'hA5A5_A5A5, 32'd0);
    send_event(KIND_MARK1,    32'h0000_10C8, 32'd0, 32'd9);     // core0 stale
    send_event(KIND_MARK0,    32'h0000_11F4, 32'd0, 32'd10);    // straight to core1 stale
    send_event(KIND_STOP,     32'h0000_1200, 32'd0, 32'd0);
    tb_now = 32'h0000_1200;
  endtask

  // Mostly session traffic with marks from both cores; time steps scale with grace
  task automatic run_traffic(input int n_items);
    logic [2:0]  kind;
    logic [31:0] span;
    int unsigned pick;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (!sess_active && pick < 40) kind = KIND_START;
      else if (pick < 3)  kind = KIND_START;
      else if (pick < 6)  kind = KIND_STOP;
      else if (pick < 46) kind = KIND_MARK0;
      else if (pick < 86) kind = KIND_MARK1;
      else if (pick < 94) kind = KIND_SNAPSHOT;
      else kind = 3'($urandom_range(KIND_SNAPSHOT + 1, KIND_LAST));
      span = (grace_us > 31'h3FFF_FFFE) ? 32'hFFFF_FFFF : {grace_us, 1'b0} + 32'd2;
      pick = $urandom_range(99);
      if (pick < 20)      tb_now = tb_now + $urandom_range(3);
      else if (pick < 85) tb_now = tb_now + $urandom_range(span);
      else if (pick < 93) tb_now = tb_now - $urandom_range(span);
      else                tb_now = $urandom();
      send_event(kind, tb_now, $urandom(), $urandom());
    end
  endtask

  // Several grace settings, the extremes among them
  task automatic test_grace_sweep();
    set_config(GRACE_RESET, $urandom(), $urandom());
    run_traffic(240);
    // a long stretch with no idling on either side
    set_config(31'd100, 32'h0000_0000, 32'hFFFF_FFFF);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    run_traffic(320);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    set_config(31'd0, $urandom(), $urandom());
    run_traffic(300);
    set_config(31'h7FFF_FFFF, $urandom(), $urandom());
    run_traffic(250);
    set_config(31'($urandom_range(1, 5000)), $urandom(), $urandom());
    run_traffic(320);
    set_config(31'($urandom()), $urandom(), $urandom());
    run_traffic(40);
  endtask

  // Receiver holds off while the sender keeps pushing, then the sender waits it out
  task automatic test_backpressure();
    set_config(31'd1000, $urandom(), $urandom());
    src_idle_en = 1'b0;
    hold_len    = 80;
    hold_tgl    = ~hold_tgl;
    run_traffic(40);
    drain_results();
    src_idle_en = 1'b1;
    run_traffic(20);
  endtask

  initial begin
    rst_ni   = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = KIND_SNAPSHOT;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_register_reset();
    test_directed_events();
    test_grace_sweep();
    test_backpressure();

    drain_results();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d events over %0d register settings: %0d feeds, %0d stale reports,",
             n_events, n_configs, n_feeds, n_stale_ev);
    $display("%0d recoveries, with random stalls and a long output hold-off.", n_recover);
    if (fail_cnt == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog on the run itself
  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
